FILE: hdl/avipt_pkg.sv
// Package: shared widths, codes and types for the AV interval pacing timer.
`timescale 1ns / 1ps
`default_nettype none

package avipt_pkg;

    localparam int TIME_W  = 17;
    localparam int RATE_W  = 8;
    localparam int REG_W   = 10;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;

    // op codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_SENSE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_NONE   = 2'd0;
    localparam logic [1:0] STAT_PACED  = 2'd1;
    localparam logic [1:0] STAT_SENSED = 2'd2;
    localparam logic [1:0] STAT_REJECT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MS   = 2'd1;

    localparam logic [REG_W-1:0] BASE_RATE_RST = 10'd240;
    localparam logic [REG_W-1:0] STEP_MS_RST   = 10'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [REG_W-1:0] base_rate;
        logic [REG_W-1:0] step_ms;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage : avipt_pkg

`default_nettype wire

FILE: hdl/avipt_cfg_regs.sv
// Configuration register file: base_rate and step_ms.
`timescale 1ns / 1ps
`default_nettype none

module avipt_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [avipt_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [avipt_pkg::REG_W-1:0]     wr_data,
    output avipt_pkg::cfg_t                      cfg
);
    import avipt_pkg::*;

    logic [REG_W-1:0] base_rate_reg;
    logic [REG_W-1:0] base_rate_next;
    logic [REG_W-1:0] step_ms_reg;
    logic [REG_W-1:0] step_ms_next;

    always_comb
    begin
        base_rate_next = base_rate_reg;
        step_ms_next   = step_ms_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_BASE_RATE: base_rate_next = wr_data;
                REG_STEP_MS:   step_ms_next   = wr_data;
                default:       ; // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_rate_reg <= BASE_RATE_RST;
            step_ms_reg   <= STEP_MS_RST;
        end
        else
        begin
            base_rate_reg <= base_rate_next;
            step_ms_reg   <= step_ms_next;
        end
    end

    assign cfg.base_rate = base_rate_reg;
    assign cfg.step_ms   = step_ms_reg;

endmodule : avipt_cfg_regs

`default_nettype wire

FILE: hdl/avipt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module avipt_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [avipt_pkg::TIME_W-1:0] dividend,
    input  wire logic [avipt_pkg::RATE_W-1:0] divisor,
    output logic      [avipt_pkg::TIME_W-1:0] quotient,
    output avipt_pkg::div_stat_t              stat
);
    import avipt_pkg::*;

    // quo_reg shifts dividend bits out at the top and quotient bits in at the bottom
    logic [TIME_W-1:0] quo_reg;
    logic [TIME_W-1:0] quo_next;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] rem_next;
    logic [RATE_W-1:0] den_reg;
    logic [RATE_W-1:0] den_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [RATE_W:0]   shifted;
    logic [RATE_W+1:0] diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~diff[RATE_W+1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(TIME_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TIME_W-2:0], ge};
            rem_next = ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule : avipt_div

`default_nettype wire

FILE: hdl/av_interval_pacing_timer_unit.sv
// Top level: AV interval pacing timer with serial timeout divider.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Word
// in        in   in_valid/in_ready    op, rate_bpm
// out       out  out_valid/out_ready  status, pace_pulse, time_left_ms
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Tick, sense, reject and unknown ops: the result is registered on accept and then
// copied to the output register once it is free; in_ready comes back with it.
// Valid start: the bit-serial divider resolves the 17-bit timeout
// (base_rate*100 / rate_bpm) one quotient bit per cycle, and the result then
// passes through the result register to the output register.
// One word in flight; in_ready drops until the result is loaded into the output
// register, which then holds it while a new word is accepted.
// Reset: idle, not running, base_rate 240, step_ms 1. cfg_ready is always high.

module av_interval_pacing_timer_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input words
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      op,
    input  wire logic [avipt_pkg::RATE_W-1:0]    rate_bpm,
    // result words
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           status,
    output logic                                 pace_pulse,
    output logic [avipt_pkg::TIME_W-1:0]         time_left_ms,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [avipt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [avipt_pkg::REG_W-1:0]     cfg_data
);
    import avipt_pkg::*;

    cfg_t              cfg;
    div_stat_t         div_stat;
    logic              div_start;
    logic [TIME_W-1:0] quotient;
    logic [TIME_W-1:0] scaled_base;

    state_t            state_reg;
    state_t            state_next;
    logic              running_reg;
    logic              running_next;
    logic [TIME_W-1:0] remaining_reg;
    logic [TIME_W-1:0] remaining_next;
    logic [1:0]        res_status_reg;
    logic [1:0]        res_status_next;
    logic              res_pulse_reg;
    logic              res_pulse_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              pace_pulse_reg;
    logic              pace_pulse_next;
    logic [TIME_W-1:0] time_left_reg;
    logic [TIME_W-1:0] time_left_next;

    logic              step_expires;

    assign cfg_ready = 1'b1;

    avipt_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // base_rate * 100 as shifts and adds: 64 + 32 + 4
    assign scaled_base = {1'b0, cfg.base_rate, 6'b0}
                       + {2'b0, cfg.base_rate, 5'b0}
                       + {5'b0, cfg.base_rate, 2'b0};

    avipt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled_base),
        .divisor  (rate_bpm),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign step_expires = remaining_reg <= {{(TIME_W-REG_W){1'b0}}, cfg.step_ms};
    assign in_ready     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        remaining_next  = remaining_reg;
        res_status_next = res_status_reg;
        res_pulse_next  = res_pulse_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        pace_pulse_next = pace_pulse_reg;
        time_left_next  = time_left_reg;
        div_start       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = STAT_NONE;
                    res_pulse_next  = 1'b0;
                    state_next      = S_DONE;
                    case (op)
                        OP_START:
                        begin
                            if ((rate_bpm == '0) || running_reg)
                            begin
                                res_status_next = STAT_REJECT;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        OP_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (step_expires)
                                begin
                                    running_next    = 1'b0;
                                    remaining_next  = '0;
                                    res_status_next = STAT_PACED;
                                    res_pulse_next  = 1'b1;
                                end
                                else
                                begin
                                    remaining_next = remaining_reg
                                        - {{(TIME_W-REG_W){1'b0}}, cfg.step_ms};
                                end
                            end
                        end
                        OP_SENSE:
                        begin
                            // sense stops the interval with no stimulus
                            if (running_reg)
                            begin
                                running_next    = 1'b0;
                                remaining_next  = '0;
                                res_status_next = STAT_SENSED;
                            end
                        end
                        default: ; // unknown op: report only
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                    if (quotient == '0)
                    begin
                        // zero timeout paces at once and stays idle
                        res_status_next = STAT_PACED;
                        res_pulse_next  = 1'b1;
                    end
                    else
                    begin
                        running_next   = 1'b1;
                        remaining_next = quotient;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    pace_pulse_next = res_pulse_reg;
                    // remaining is held at zero whenever the timer is idle
                    time_left_next  = remaining_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= 1'b0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_pulse_reg  <= res_pulse_next;
        status_reg     <= status_next;
        pace_pulse_reg <= pace_pulse_next;
        time_left_reg  <= time_left_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign pace_pulse   = pace_pulse_reg;
    assign time_left_ms = time_left_reg;

    // idle timer always carries zero remaining time
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (remaining_reg == '0))
        else $error("remaining time nonzero while idle");

    // a pulse goes out with the paced status and no other
    a_pulse_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pace_pulse == (status == STAT_PACED)))
        else $error("pace_pulse and status disagree");

    // divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // no new word is taken while the divider is busy
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !in_ready)
        else $error("input accepted during division");

endmodule : av_interval_pacing_timer_unit

`default_nettype wire
